// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms for the result channel checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("line edit buffer: assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("line edit buffer: assertion failed");

`endif

// ===== sv/cleb_pkg.sv =====
// ----------------------------------------------------------------------------
// cleb_pkg
// Types and constants shared by the console line edit buffer.
// ----------------------------------------------------------------------------
package cleb_pkg;

  localparam int BUFFER_DEPTH_DEF = 64;
  localparam int QUEUE_DEPTH      = 2;

  localparam logic [7:0] KEY_TAB       = 8'd9;
  localparam logic [7:0] KEY_RETURN    = 8'd13;
  localparam logic [7:0] KEY_BACKSPACE = 8'd127;
  localparam logic [7:0] KEY_SPACE     = 8'd32;
  localparam logic [7:0] KEY_TILDE     = 8'd126;
  localparam logic [7:0] CHR_NEWLINE   = 8'd10;
  localparam logic [7:0] CHR_BS        = 8'd8;
  localparam logic [7:0] CHR_CARET     = 8'd94;
  localparam logic [7:0] CTRL_OFFSET   = 8'd64;

  localparam logic [7:0] WAKE_ONE = 8'd0;
  localparam logic [7:0] WAKE_ALL = 8'd1;

  localparam logic [2:0] KIND_ECHO      = 3'd0;
  localparam logic [2:0] KIND_WAKE      = 3'd1;
  localparam logic [2:0] KIND_CHAR      = 3'd2;
  localparam logic [2:0] KIND_EOL       = 3'd3;
  localparam logic [2:0] KIND_EMPTY     = 3'd4;
  localparam logic [2:0] KIND_NOT_READY = 3'd5;

  localparam logic [15:0] COLUMN_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    OP_PRINT,
    OP_RETURN,
    OP_BACKSPACE,
    OP_CTRL,
    OP_READ
  } op_cls_t;

  // one classified word on its way to the back end
  typedef struct packed {
    op_cls_t    cls;
    logic [7:0] key;
  } op_t;

endpackage

// ===== sv/console_line_edit_buffer.sv =====
// ----------------------------------------------------------------------------
// Console line edit buffer.
// Input channel (item_valid/item_stall, cmd, key): cmd 0 delivers a keystroke,
// cmd 1 asks to pop one byte from the line store. A word is taken at a rising
// edge with item_valid high and item_stall low.
// Output channel (res_valid/res_stall, kind, data, last): zero to three result
// words per input word, last set on the final one. Echo and wake words come
// from keystrokes; read words carry a character, end-of-line, empty or not
// ready. echo_enable is written through cfg_wr_en/cfg_wr_data; the user must
// write it only while idle; the block itself does not enforce it. A taken
// word passes the queue, the execute stage and the output register, and a
// word that reads the line store (pop, or backspace on a non-empty line) also
// waits for the registered store read. The execute stage takes a new word only
// when idle; the two-word queue ahead lets input words in while results drain.
// Reset (rst, synchronous) empties the buffer and queue, clears the column and
// line count and sets echo on. The store itself is not cleared.
// A stalled result word holds; the execute stage and then the queue back up,
// and item_stall rises when the queue is full.
// ----------------------------------------------------------------------------
module console_line_edit_buffer
  import cleb_pkg::*;
#(
  parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  input  logic       item_valid,
  output logic       item_stall,
  input  logic       cmd,
  input  logic [7:0] key,
  output logic       res_valid,
  input  logic       res_stall,
  output logic [2:0] kind,
  output logic [7:0] data,
  output logic       last
);

  logic op_valid;
  op_t  op;
  logic op_pop;

  cleb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .cmd        (cmd),
    .key        (key),
    .op_valid   (op_valid),
    .op         (op),
    .op_pop     (op_pop)
  );

  cleb_back #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .op_valid    (op_valid),
    .op          (op),
    .op_pop      (op_pop),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .kind        (kind),
    .data        (data),
    .last        (last)
  );

endmodule

// ===== sv/cleb_ram.sv =====
// ----------------------------------------------------------------------------
// cleb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cleb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/cleb_front.sv =====
// ----------------------------------------------------------------------------
// cleb_front
// Accepts input words, classifies the key and queues the result.
// ----------------------------------------------------------------------------
module cleb_front
  import cleb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  logic       cmd,
  input  logic [7:0] key,
  output logic       op_valid,
  output op_t        op,
  input  logic       op_pop
);

  localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  op_t            entries [QUEUE_DEPTH];
  logic [QAW-1:0] wptr;
  logic [QAW-1:0] rptr;
  logic [QCW-1:0] count;
  logic           push;
  logic           pop;
  op_t            op_in;

  always_comb begin
    op_in.key = key;
    priority if (cmd) begin
      op_in.cls = OP_READ;
    end else if (key == KEY_BACKSPACE) begin
      op_in.cls = OP_BACKSPACE;
    end else if (key == KEY_RETURN) begin
      op_in.cls = OP_RETURN;
    end else if (key == KEY_TAB || (key >= KEY_SPACE && key <= KEY_TILDE)) begin
      op_in.cls = OP_PRINT;
    end else begin
      op_in.cls = OP_CTRL;
    end
  end

  assign item_stall = (count == QCW'(QUEUE_DEPTH));
  assign push       = item_valid && !item_stall;
  assign op_valid   = (count != '0);
  assign pop        = op_pop && op_valid;
  assign op         = entries[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= op_in;
    end
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == QAW'(QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == QAW'(QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== sv/cleb_back.sv =====
// ----------------------------------------------------------------------------
// cleb_back
// Executes classified words against the line store and emits result words.
// ----------------------------------------------------------------------------
module cleb_back
  import cleb_pkg::*;
#(
  parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  input  logic       op_valid,
  input  op_t        op,
  output logic       op_pop,
  output logic       res_valid,
  input  logic       res_stall,
  output logic [2:0] kind,
  output logic [7:0] data,
  output logic       last
);

  localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int CW = $clog2(BUFFER_DEPTH + 1);
  localparam int SW = AW + 1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t         state, state_next;
  logic [CW-1:0]  fill, fill_next;
  logic [CW-1:0]  line_end, line_end_next;
  logic [AW-1:0]  oldest, oldest_next;
  logic [15:0]    column, column_next;
  logic           echo_en;
  logic           pend_pop, pend_pop_next;
  logic [2:0]     rk [3];
  logic [7:0]     rd [3];
  logic [2:0]     rk_next [3];
  logic [7:0]     rd_next [3];
  logic [1:0]     rn, rn_next;
  logic [1:0]     ri, ri_next;

  logic           ram_we, ram_re;
  logic [AW-1:0]  ram_raddr;
  logic [AW-1:0]  slot_wr, slot_bs;
  logic [7:0]     ram_rdata;
  logic [SW-1:0]  sum_wr, sum_bs;
  logic [AW-1:0]  oldest_inc;
  logic [15:0]    col_inc;
  logic           full;
  logic           out_free;
  logic           out_load;

  assign full     = (fill == CW'(BUFFER_DEPTH));
  assign sum_wr   = SW'(oldest) + SW'(fill);
  assign sum_bs   = SW'(oldest) + SW'(fill) - SW'(1);
  // sums stay below twice the depth, so one subtract wraps them
  assign slot_wr  = (sum_wr >= SW'(BUFFER_DEPTH)) ? AW'(sum_wr - SW'(BUFFER_DEPTH))
                                                  : AW'(sum_wr);
  assign slot_bs  = (sum_bs >= SW'(BUFFER_DEPTH)) ? AW'(sum_bs - SW'(BUFFER_DEPTH))
                                                  : AW'(sum_bs);
  assign oldest_inc = (oldest == AW'(BUFFER_DEPTH - 1)) ? '0 : oldest + 1'b1;
  assign col_inc    = (column == COLUMN_MAX) ? column : column + 16'd1;

  assign out_free = !res_valid || !res_stall;
  assign op_pop   = (state == ST_IDLE) && op_valid;

  cleb_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_wr),
    .wdata (op.key),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next    = state;
    fill_next     = fill;
    line_end_next = line_end;
    oldest_next   = oldest;
    column_next   = column;
    pend_pop_next = pend_pop;
    rn_next       = rn;
    ri_next       = ri;
    for (int i = 0; i < 3; i++) begin
      rk_next[i] = rk[i];
      rd_next[i] = rd[i];
    end
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = oldest;
    out_load  = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (op_valid) begin
          ri_next = '0;
          rn_next = '0;
          for (int i = 0; i < 3; i++) begin
            rk_next[i] = KIND_ECHO;
            rd_next[i] = '0;
          end
          unique case (op.cls)
            OP_READ: begin
              if (line_end == '0 && !full) begin
                rk_next[0] = KIND_NOT_READY;
                rn_next    = 2'd1;
              end else if (fill == '0) begin
                rk_next[0] = KIND_EMPTY;
                rn_next    = 2'd1;
              end else begin
                ram_re        = 1'b1;
                ram_raddr     = oldest;
                oldest_next   = oldest_inc;
                fill_next     = fill - 1'b1;
                pend_pop_next = 1'b1;
              end
            end
            OP_BACKSPACE: begin
              if (echo_en && column != '0) begin
                column_next = column - 16'd1;
                rd_next[0]  = CHR_BS;
                rd_next[1]  = KEY_SPACE;
                rd_next[2]  = CHR_BS;
                rn_next     = 2'd3;
              end
              if (fill != '0) begin
                // a stored return survives; decided once the byte is back
                ram_re        = 1'b1;
                ram_raddr     = slot_bs;
                pend_pop_next = 1'b0;
              end
            end
            OP_PRINT, OP_RETURN, OP_CTRL: begin
              if (full) begin
                if (op.cls == OP_RETURN) begin
                  rk_next[0] = KIND_WAKE;
                  rd_next[0] = WAKE_ALL;
                  rn_next    = 2'd1;
                end
              end else begin
                ram_we    = 1'b1;
                fill_next = fill + 1'b1;
                if (op.cls == OP_RETURN) begin
                  line_end_next = line_end + 1'b1;
                  if (echo_en) begin
                    column_next = '0;
                    rd_next[0]  = CHR_NEWLINE;
                    rk_next[1]  = KIND_WAKE;
                    rd_next[1]  = WAKE_ONE;
                    rn_next     = 2'd2;
                  end else begin
                    rk_next[0] = KIND_WAKE;
                    rd_next[0] = WAKE_ONE;
                    rn_next    = 2'd1;
                  end
                end else if (echo_en) begin
                  column_next = col_inc;
                  if (op.cls == OP_PRINT) begin
                    rd_next[0] = op.key;
                    rn_next    = 2'd1;
                  end else begin
                    rd_next[0] = CHR_CARET;
                    rd_next[1] = op.key + CTRL_OFFSET;
                    rn_next    = 2'd2;
                  end
                end
              end
            end
            default: ;
          endcase
          if (ram_re) begin
            state_next = ST_READ;
          end else if (rn_next != '0) begin
            state_next = ST_EMIT;
          end
        end
      end

      ST_READ: begin
        if (pend_pop) begin
          if (ram_rdata == KEY_RETURN) begin
            if (line_end != '0) begin
              line_end_next = line_end - 1'b1;
            end
            rk_next[0] = KIND_EOL;
            rd_next[0] = KEY_RETURN;
          end else begin
            rk_next[0] = KIND_CHAR;
            rd_next[0] = ram_rdata;
          end
          rn_next    = 2'd1;
          state_next = ST_EMIT;
        end else begin
          if (ram_rdata != KEY_RETURN) begin
            fill_next = fill - 1'b1;
          end
          state_next = (rn != '0) ? ST_EMIT : ST_IDLE;
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          ri_next  = ri + 1'b1;
          if (ri == rn - 2'd1) begin
            state_next = ST_IDLE;
          end
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    pend_pop <= pend_pop_next;
    rn       <= rn_next;
    ri       <= ri_next;
    for (int i = 0; i < 3; i++) begin
      rk[i] <= rk_next[i];
      rd[i] <= rd_next[i];
    end
    if (out_load) begin
      kind <= rk[ri];
      data <= rd[ri];
      last <= (ri == rn - 2'd1);
    end
    if (rst) begin
      state     <= ST_IDLE;
      fill      <= '0;
      line_end  <= '0;
      oldest    <= '0;
      column    <= '0;
      echo_en   <= 1'b1;
      res_valid <= 1'b0;
    end else begin
      state    <= state_next;
      fill     <= fill_next;
      line_end <= line_end_next;
      oldest   <= oldest_next;
      column   <= column_next;
      if (cfg_wr_en) begin
        echo_en <= cfg_wr_data;
      end
      if (out_load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== sv/cleb_checker.sv =====
// ----------------------------------------------------------------------------
// cleb_checker
// Port-level checks on the result channel of the line edit buffer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cleb_checker
  import cleb_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_stall,
  input logic [2:0] kind,
  input logic [7:0] data,
  input logic       last
);

  // a stalled result word holds
  `ASSERT_NEXT(a_res_hold, clk, rst, res_valid && res_stall, res_valid && $stable(kind) && $stable(data) && $stable(last))

  // a read gives exactly one word
  `ASSERT_IMPL(a_read_single, clk, rst, res_valid && (kind == KIND_CHAR || kind == KIND_EOL || kind == KIND_EMPTY || kind == KIND_NOT_READY), last)

  // wake always closes the keystroke's words
  `ASSERT_IMPL(a_wake_last, clk, rst, res_valid && kind == KIND_WAKE, last && (data == WAKE_ONE || data == WAKE_ALL))

  // end-of-line carries the return byte
  `ASSERT_IMPL(a_eol_data, clk, rst, res_valid && kind == KIND_EOL, data == KEY_RETURN)

endmodule

bind console_line_edit_buffer cleb_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .kind      (kind),
  .data      (data),
  .last      (last)
);

// ===== verif/console_line_edit_buffer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// console_line_edit_buffer_tb
// Self-checking bench for the console line edit buffer. Keystroke and read
// words are driven with random gaps on both channels. Every result word is
// compared with the expectation of a directed row that gives one, or else
// with a behavioural line discipline kept in the bench. The run covers directed
// edge cases, random line traffic at both echo settings and buffer overflow.
// ----------------------------------------------------------------------------
module console_line_edit_buffer_tb;
  import cleb_pkg::*;

  localparam int  DEPTH      = BUFFER_DEPTH_DEF;
  localparam int  STUCK_MAX  = 4000;
  localparam int  SETTLE     = 16;
  localparam bit  CMD_KEY    = 1'b0;
  localparam bit  CMD_READ   = 1'b1;
  localparam int  TYPED_NONE = -1;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
    logic       last;
  } out_word_t;

  typedef struct {
    bit          c;
    logic [7:0]  k;
    int          n;
    out_word_t   r [3];
  } plan_row_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       cfg_wr_en = 1'b0;
  logic       cfg_wr_data = 1'b0;
  logic       item_valid = 1'b0;
  logic       item_stall;
  logic       cmd = 1'b0;
  logic [7:0] key = 8'd0;
  logic       res_valid;
  logic       res_stall = 1'b0;
  logic [2:0] kind;
  logic [7:0] data;
  logic       last;

  console_line_edit_buffer DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .cmd         (cmd),
    .key         (key),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .kind        (kind),
    .data        (data),
    .last        (last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // line discipline model state
  logic [7:0]  line_buf [DEPTH];
  int          head;
  int          fill;
  int          line_ends;
  logic [15:0] column;
  bit          echo_on;

  out_word_t   step_res [3];
  int          step_n;
  out_word_t   due_q [$];
  plan_row_t   plan_q [$];

  int faults    = 0;
  int sent      = 0;
  int res_taken = 0;
  int res_seen  = 0;
  int hold_left = 0;
  bit quiet     = 1'b0;

  function automatic void add_res(logic [2:0] kd, logic [7:0] dt);
    step_res[step_n] = '{kind: kd, data: dt, last: 1'b0};
    step_n++;
  endfunction

  function automatic void bump_column();
    if (column != COLUMN_MAX) column++;
  endfunction

  function automatic void echo_key(logic [7:0] k);
    if (!echo_on) return;
    if ((k >= KEY_SPACE && k <= KEY_TILDE) || k == KEY_TAB) begin
      bump_column();
      add_res(KIND_ECHO, k);
    end else if (k == KEY_RETURN) begin
      column = 16'd0;
      add_res(KIND_ECHO, CHR_NEWLINE);
    end else if (k == KEY_BACKSPACE) begin
      if (column != 16'd0) begin
        column--;
        add_res(KIND_ECHO, CHR_BS);
        add_res(KIND_ECHO, KEY_SPACE);
        add_res(KIND_ECHO, CHR_BS);
      end
    end else begin
      bump_column();
      add_res(KIND_ECHO, CHR_CARET);
      add_res(KIND_ECHO, k + CTRL_OFFSET);
    end
  endfunction

  // advance the model by one word; results land in step_res
  function automatic void line_discipline(bit c, logic [7:0] k);
    logic [7:0] ch;
    step_n = 0;
    if (c == CMD_KEY) begin
      if (k == KEY_BACKSPACE) begin
        echo_key(k);
        // a stored return is never erased
        if (fill > 0 && line_buf[(head + fill - 1) % DEPTH] != KEY_RETURN) fill--;
      end else if (fill >= DEPTH) begin
        if (k == KEY_RETURN) add_res(KIND_WAKE, WAKE_ALL);
      end else begin
        echo_key(k);
        line_buf[(head + fill) % DEPTH] = k;
        fill++;
        if (k == KEY_RETURN) begin
          line_ends++;
          add_res(KIND_WAKE, WAKE_ONE);
        end
      end
    end else begin
      if (line_ends == 0 && fill < DEPTH) begin
        add_res(KIND_NOT_READY, 8'd0);
      end else if (fill == 0) begin
        add_res(KIND_EMPTY, 8'd0);
      end else begin
        ch   = line_buf[head];
        head = (head + 1) % DEPTH;
        fill--;
        if (ch == KEY_RETURN) begin
          if (line_ends > 0) line_ends--;
          add_res(KIND_EOL, KEY_RETURN);
        end else begin
          add_res(KIND_CHAR, ch);
        end
      end
    end
    if (step_n > 0) step_res[step_n-1].last = 1'b1;
  endfunction

  function automatic logic [7:0] rand_key(bit allow_bs);
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 5)                   return 8'($urandom_range(32, 126));
    else if (pick == 5)             return KEY_TAB;
    else if (pick == 6 && allow_bs) return KEY_BACKSPACE;
    else if (pick == 7)             return 8'($urandom_range(0, 31));
    else if (pick == 8)             return 8'($urandom_range(128, 255));
    else                            return 8'($urandom_range(0, 255));
  endfunction

  // drive one word; a typed row supplies its own expectation
  task automatic put_word(bit c, logic [7:0] k, int n = TYPED_NONE,
                          out_word_t r [3] = '{default: '0});
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 14);
    @(negedge clk);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_valid <= 1'b1;
    cmd        <= c;
    key        <= k;
    line_discipline(c, k);
    if (n == TYPED_NONE) begin
      for (int i = 0; i < step_n; i++) due_q.push_back(step_res[i]);
    end else begin
      for (int i = 0; i < n; i++) begin
        r[i].last = (i == n - 1);
        due_q.push_back(r[i]);
      end
    end
    sent++;
    do @(posedge clk); while (item_stall);
  endtask

  task automatic drain();
    @(negedge clk);
    item_valid <= 1'b0;
    while (due_q.size() != 0) @(posedge clk);
    // words that cause no result may still be in flight
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_echo(bit v);
    drain();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    echo_on = v;
  endtask

  task automatic add_row(bit c, logic [7:0] k, int n = TYPED_NONE,
                         logic [2:0] k0 = 0, logic [7:0] d0 = 0,
                         logic [2:0] k1 = 0, logic [7:0] d1 = 0,
                         logic [2:0] k2 = 0, logic [7:0] d2 = 0);
    plan_row_t row;
    row.c    = c;
    row.k    = k;
    row.n    = n;
    row.r[0] = '{kind: k0, data: d0, last: 1'b0};
    row.r[1] = '{kind: k1, data: d1, last: 1'b0};
    row.r[2] = '{kind: k2, data: d2, last: 1'b0};
    plan_q.push_back(row);
  endtask

  task automatic random_traffic(int target);
    int len;
    int pick;
    while (sent < target) begin
      quiet = ($urandom_range(0, 4) == 0);
      pick  = $urandom_range(0, 19);
      if (pick < 12) begin
        // one well-formed line, then read it back
        len = $urandom_range(0, 12);
        repeat (len) put_word(CMD_KEY, rand_key(1'b1));
        put_word(CMD_KEY, KEY_RETURN);
        repeat (len + $urandom_range(1, 3)) put_word(CMD_READ, 8'($urandom()));
      end else if (pick < 15) begin
        // a long line that may overrun the buffer, then a return that is dropped if full
        len = $urandom_range(60, 70);
        repeat (len) put_word(CMD_KEY, rand_key(1'b0));
        put_word(CMD_KEY, KEY_RETURN);
        if ($urandom_range(0, 1)) put_word(CMD_KEY, KEY_BACKSPACE);
        repeat ($urandom_range(0, 70)) put_word(CMD_READ, 8'($urandom()));
      end else begin
        put_word(1'($urandom()), 8'($urandom()));
      end
    end
  endtask

  // result checker
  always @(posedge clk) begin
    out_word_t want;
    if (!rst && res_valid && !res_stall) begin
      res_taken++;
      if (due_q.size() == 0) begin
        $display("%0t unexpected word: kind %0d data %0d last %0d",
                 $time, kind, data, last);
        faults++;
      end else begin
        want = due_q.pop_front();
        if (kind !== want.kind) begin
          $display("%0t kind mismatch: expected %0d actual %0d", $time, want.kind, kind);
          faults++;
        end
        if (data !== want.data) begin
          $display("%0t data mismatch: expected %0d actual %0d", $time, want.data, data);
          faults++;
        end
        if (last !== want.last) begin
          $display("%0t last mismatch: expected %0d actual %0d", $time, want.last, last);
          faults++;
        end
      end
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      res_stall <= 1'b1;
    end else if (res_taken != res_seen) begin
      res_seen  = res_taken;
      hold_left = quiet ? 0 : $urandom_range(0, 14);
      if (hold_left > 0) begin
        hold_left--;
        res_stall <= 1'b1;
      end else begin
        res_stall <= 1'b0;
      end
    end else begin
      res_stall <= !quiet && ($urandom_range(0, 7) == 0);
    end
  end

  // watchdog on cycles with no word moving
  initial begin
    int stuck;
    stuck = 0;
    while (stuck < STUCK_MAX) begin
      @(posedge clk);
      if ((item_valid && !item_stall) || (res_valid && !res_stall)) stuck = 0;
      else stuck++;
    end
    $display("%0t watchdog expired, %0d words outstanding", $time, due_q.size());
    $display("console_line_edit_buffer_tb: FAIL");
    $finish;
  end

  initial begin
    head      = 0;
    fill      = 0;
    line_ends = 0;
    column    = 16'd0;
    echo_on   = 1'b1;
    for (int i = 0; i < DEPTH; i++) line_buf[i] = 8'd0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    set_echo(1'b1);

    add_row(CMD_READ, 8'd0,   1, KIND_NOT_READY, 8'd0);
    add_row(CMD_KEY,  KEY_BACKSPACE, 0);
    add_row(CMD_KEY,  8'd32,  1, KIND_ECHO, 8'd32);
    add_row(CMD_KEY,  8'd126, 1, KIND_ECHO, 8'd126);
    add_row(CMD_KEY,  KEY_TAB, 1, KIND_ECHO, KEY_TAB);
    add_row(CMD_KEY,  8'd0,   2, KIND_ECHO, CHR_CARET, KIND_ECHO, 8'd64);
    add_row(CMD_KEY,  8'd255, 2, KIND_ECHO, CHR_CARET, KIND_ECHO, 8'd63);
    add_row(CMD_KEY,  8'd128);
    add_row(CMD_KEY,  8'd31);
    add_row(CMD_KEY,  KEY_BACKSPACE, 3, KIND_ECHO, CHR_BS, KIND_ECHO, KEY_SPACE,
            KIND_ECHO, CHR_BS);
    add_row(CMD_KEY,  KEY_RETURN, 2, KIND_ECHO, CHR_NEWLINE, KIND_WAKE, WAKE_ONE);
    // column is zero and the newest byte is a return: nothing at all
    add_row(CMD_KEY,  KEY_BACKSPACE, 0);
    repeat (6) add_row(CMD_READ, 8'hFF);
    add_row(CMD_READ, 8'hA5, 1, KIND_EOL, KEY_RETURN);
    add_row(CMD_READ, 8'h5A, 1, KIND_NOT_READY, 8'd0);

    foreach (plan_q[i]) put_word(plan_q[i].c, plan_q[i].k, plan_q[i].n, plan_q[i].r);

    set_echo(1'b1);
    random_traffic(sent + 200);
    set_echo(1'b0);
    random_traffic(sent + 150);
    set_echo(1'b1);
    random_traffic(sent + 150);

    drain();
    if (faults == 0) $display("console_line_edit_buffer_tb: PASS");
    else             $display("console_line_edit_buffer_tb: FAIL");
    $finish;
  end

endmodule
